// ----- hdl/amfs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the AVI movi frame scanner.
// Holds tag codes, register reset values, phase/cause enums and the result record.
// No dependencies.
package amfs_pkg;

  localparam int unsigned PosW      = 33;
  localparam int unsigned SumW      = PosW + 2;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

  localparam logic [31:0] TagMovi = 32'h6D6F7669;
  localparam logic [31:0] TagVid  = 32'h30306462;
  localparam logic [31:0] TagAud  = 32'h30317762;
  localparam logic [31:0] TagIdx  = 32'h69647831;

  localparam logic [31:0] FileSizeRst  = 32'd0;
  localparam logic [31:0] SizeFloorRst = 32'd100;
  localparam logic [31:0] SizeCeilRst  = 32'd1000000;
  localparam logic [15:0] MaxFramesRst = 16'd10000;

  typedef enum logic [1:0] {
    CFG_FILE_SIZE  = 2'd0,
    CFG_SIZE_FLOOR = 2'd1,
    CFG_SIZE_CEIL  = 2'd2,
    CFG_MAX_FRAMES = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_WALK   = 2'd1,
    PH_OWED   = 2'd2,
    PH_DONE   = 2'd3
  } scan_phase_e;

  typedef enum logic {
    KIND_FRAME = 1'b0,
    KIND_DONE  = 1'b1
  } result_kind_e;

  typedef enum logic [1:0] {
    CAUSE_INDEX = 2'd0,
    CAUSE_CAP   = 2'd1,
    CAUSE_EOS   = 2'd2
  } end_cause_e;

  typedef struct packed {
    result_kind_e kind;
    logic [31:0]  offset;
    logic [31:0]  size;
    logic [15:0]  count;
    end_cause_e   cause;
    logic         last;
  } result_t;

  function automatic logic [PosW-1:0] sat_pos(input logic [SumW-1:0] v);
    logic [PosW-1:0] r;
    if (|v[SumW-1:PosW]) begin
      r = PosMax;
    end else begin
      r = v[PosW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/avi_movi_frame_scanner_core.sv -----
`timescale 1ns / 1ps
// Top level of the AVI movi frame scanner: byte window, chunk walk and result queue.
// Depends on amfs_pkg.
//
//   channel   signals                                  direction
//   input     in_valid_i / in_ready_o, byte fields     one file byte per transaction
//   output    out_valid_o / out_ready_i, result fields frame descriptor or done record
//   config    cfg_we_i, cfg_index_i, cfg_wdata_i       register write, no wait
//
// One byte is taken per cycle while in_ready_o is high; its decision and up to two
// results are computed in the same cycle and written into a four-entry result queue.
// Input is ready while the queue has room for two results, so bytes keep
// flowing while up to two earlier results wait. Reset clears all state,
// the queue and the registers to their defaults.
module avi_movi_frame_scanner_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_value_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [31:0] frame_offset_o,
  output logic [31:0] frame_size_o,
  output logic [15:0] frame_count_o,
  output logic [1:0]  end_cause_o,
  output logic        last_of_run_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int unsigned PosW = amfs_pkg::PosW;
  localparam int unsigned SumW = amfs_pkg::SumW;
  localparam int unsigned PtrW = amfs_pkg::PtrW;
  localparam int unsigned CntW = amfs_pkg::CntW;

  logic [31:0] file_size_q, size_floor_q, size_ceil_q;
  logic [15:0] max_frames_q;

  logic [63:0]            window_q, window_d;
  logic [PosW-1:0]        pos_q, pos_d;
  logic [PosW-1:0]        next_q, next_d;
  amfs_pkg::scan_phase_e  phase_q, phase_d;
  logic [15:0]            frames_q, frames_d;

  amfs_pkg::result_t      fifo_q [amfs_pkg::FifoDepth];
  logic [PtrW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]        fill_q;

  logic                   in_fire, out_fire;
  logic [63:0]            win_new;
  logic [31:0]            tag, chunk_size;
  logic                   decide, in_bound, walk_dec, cap_hit, cap_after, size_ok;
  logic                   is_movi, is_vid, is_aud, is_idx;
  logic                   ev_frame, stop_cap_pre, stop_cap_post, stop_idx, stop_dec, ev_eos;
  logic [15:0]            frames_inc;
  logic [SumW-1:0]        frame_end, skip_end;
  amfs_pkg::end_cause_e   dec_cause;
  amfs_pkg::result_t      res_a, res_b;
  logic [1:0]             res_n;

  assign in_ready_o = (fill_q <= CntW'(amfs_pkg::FifoDepth - 2));
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_valid_o = (fill_q != '0);
  assign out_fire   = out_valid_o && out_ready_i;

  // Decode the window as it stands with the new byte shifted in.
  assign win_new    = {window_q[55:0], byte_value_i};
  assign tag        = win_new[63:32];
  assign chunk_size = {win_new[7:0], win_new[15:8], win_new[23:16], win_new[31:24]};

  assign is_movi = (tag == amfs_pkg::TagMovi);
  assign is_vid  = (tag == amfs_pkg::TagVid);
  assign is_aud  = (tag == amfs_pkg::TagAud);
  assign is_idx  = (tag == amfs_pkg::TagIdx);

  assign decide   = ((phase_q == amfs_pkg::PH_SEARCH) || (phase_q == amfs_pkg::PH_WALK)) &&
                    ({1'b0, pos_q} == ({1'b0, next_q} + (PosW+1)'(7)));
  assign in_bound = (({1'b0, next_q} + (PosW+1)'(8)) < (PosW+1)'(file_size_q));
  assign walk_dec = decide && in_bound && (phase_q == amfs_pkg::PH_WALK);

  assign frame_end  = SumW'(next_q) + SumW'(8) + SumW'(chunk_size);
  assign skip_end   = frame_end + SumW'(chunk_size[0]);
  assign size_ok    = (chunk_size > size_floor_q) && (chunk_size < size_ceil_q) &&
                      (frame_end <= SumW'(file_size_q));
  assign frames_inc = frames_q + 16'd1;
  assign cap_hit    = (frames_q >= max_frames_q);
  assign cap_after  = (frames_inc >= max_frames_q);

  assign stop_cap_pre  = walk_dec && cap_hit;
  assign ev_frame      = walk_dec && !cap_hit && is_vid && size_ok;
  assign stop_cap_post = ev_frame && cap_after;
  assign stop_idx      = walk_dec && !cap_hit && !is_vid && !is_aud && is_idx;
  assign stop_dec      = stop_cap_pre || stop_cap_post || stop_idx;
  assign dec_cause     = stop_idx ? amfs_pkg::CAUSE_INDEX : amfs_pkg::CAUSE_CAP;
  assign ev_eos        = last_byte_i && !stop_dec && (phase_q != amfs_pkg::PH_DONE);

  // Next state of the scan.
  always_comb begin
    window_d = win_new;
    pos_d    = (pos_q == amfs_pkg::PosMax) ? amfs_pkg::PosMax : pos_q + PosW'(1);
    next_d   = next_q;
    phase_d  = phase_q;
    frames_d = frames_q;
    if (decide) begin
      priority if (!in_bound) begin
        phase_d = amfs_pkg::PH_OWED;
      end else if (phase_q == amfs_pkg::PH_SEARCH) begin
        if (is_movi) begin
          phase_d = amfs_pkg::PH_WALK;
          next_d  = amfs_pkg::sat_pos(SumW'(next_q) + SumW'(4));
        end else begin
          next_d  = amfs_pkg::sat_pos(SumW'(next_q) + SumW'(1));
        end
      end else if (cap_hit) begin
        phase_d = amfs_pkg::PH_DONE;
      end else if (is_vid) begin
        if (size_ok) begin
          frames_d = frames_inc;
          next_d   = amfs_pkg::sat_pos(skip_end);
          if (cap_after) begin
            phase_d = amfs_pkg::PH_DONE;
          end
        end else begin
          next_d = amfs_pkg::sat_pos(SumW'(next_q) + SumW'(8));
        end
      end else if (is_aud) begin
        next_d = amfs_pkg::sat_pos(skip_end);
      end else if (is_idx) begin
        phase_d = amfs_pkg::PH_DONE;
      end else begin
        next_d = amfs_pkg::sat_pos(SumW'(next_q) + SumW'(1));
      end
    end
    if (last_byte_i) begin
      window_d = '0;
      pos_d    = '0;
      next_d   = '0;
      phase_d  = amfs_pkg::PH_SEARCH;
      frames_d = '0;
    end
  end

  // Results caused by this byte, in order.
  always_comb begin
    res_n = 2'(ev_frame) + 2'(stop_dec) + 2'(ev_eos);

    res_a.kind   = amfs_pkg::KIND_DONE;
    res_a.offset = '0;
    res_a.size   = '0;
    res_a.count  = stop_cap_post ? 16'd0 : frames_q;
    res_a.cause  = stop_dec ? dec_cause : amfs_pkg::CAUSE_EOS;
    res_a.last   = (res_n == 2'd1);
    if (ev_frame) begin
      res_a.kind   = amfs_pkg::KIND_FRAME;
      res_a.offset = 32'(next_q + PosW'(8));
      res_a.size   = chunk_size;
      res_a.count  = '0;
      res_a.cause  = amfs_pkg::CAUSE_INDEX;
    end

    res_b.kind   = amfs_pkg::KIND_DONE;
    res_b.offset = '0;
    res_b.size   = '0;
    res_b.count  = frames_inc;
    res_b.cause  = stop_dec ? dec_cause : amfs_pkg::CAUSE_EOS;
    res_b.last   = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_size_q  <= amfs_pkg::FileSizeRst;
      size_floor_q <= amfs_pkg::SizeFloorRst;
      size_ceil_q  <= amfs_pkg::SizeCeilRst;
      max_frames_q <= amfs_pkg::MaxFramesRst;
    end else if (cfg_we_i) begin
      unique case (amfs_pkg::cfg_reg_e'(cfg_index_i))
        amfs_pkg::CFG_FILE_SIZE:  file_size_q  <= cfg_wdata_i;
        amfs_pkg::CFG_SIZE_FLOOR: size_floor_q <= cfg_wdata_i;
        amfs_pkg::CFG_SIZE_CEIL:  size_ceil_q  <= cfg_wdata_i;
        amfs_pkg::CFG_MAX_FRAMES: max_frames_q <= cfg_wdata_i[15:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      pos_q    <= '0;
      next_q   <= '0;
      phase_q  <= amfs_pkg::PH_SEARCH;
      frames_q <= '0;
    end else if (in_fire) begin
      window_q <= window_d;
      pos_q    <= pos_d;
      next_q   <= next_d;
      phase_q  <= phase_d;
      frames_q <= frames_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && (res_n != 2'd0)) begin
      fifo_q[wr_ptr_q] <= res_a;
      if (res_n == 2'd2) begin
        fifo_q[wr_ptr_q + PtrW'(1)] <= res_b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(res_n);
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      fill_q <= fill_q + (in_fire ? CntW'(res_n) : CntW'(0)) - CntW'(out_fire);
    end
  end

  assign result_kind_o  = fifo_q[rd_ptr_q].kind;
  assign frame_offset_o = fifo_q[rd_ptr_q].offset;
  assign frame_size_o   = fifo_q[rd_ptr_q].size;
  assign frame_count_o  = fifo_q[rd_ptr_q].count;
  assign end_cause_o    = fifo_q[rd_ptr_q].cause;
  assign last_of_run_o  = fifo_q[rd_ptr_q].last;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(amfs_pkg::FifoDepth))
    else $error("result queue overfilled");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && last_byte_i |=> (pos_q == '0) && (phase_q == amfs_pkg::PH_SEARCH) &&
                               (frames_q == '0))
    else $error("scan state not cleared after last byte");

  a_stop_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && stop_dec && !last_byte_i |=> phase_q == amfs_pkg::PH_DONE)
    else $error("walk stop did not reach done phase");

  a_two_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> !(ev_frame && stop_dec && ev_eos))
    else $error("more than two results from one byte");
`endif

endmodule

// ----- bench/tb_avi_movi_frame_scanner_core.sv -----
`timescale 1ns / 1ps
// Testbench for avi_movi_frame_scanner_core: streams synthetic AVI byte files and checks
// every frame descriptor and done record against a built-in scan predictor.
// Depends on amfs_pkg and the avi_movi_frame_scanner_core RTL.
module tb_avi_movi_frame_scanner_core;

  localparam int CycleLimit  = 400000;
  localparam int SettleCycles = 8;
  localparam int ByteTarget  = 975;

  class frame_scan_board;
    logic [31:0] file_size  = amfs_pkg::FileSizeRst;
    logic [31:0] size_floor = amfs_pkg::SizeFloorRst;
    logic [31:0] size_ceil  = amfs_pkg::SizeCeilRst;
    logic [15:0] frame_cap  = amfs_pkg::MaxFramesRst;

    logic [63:0] window;
    logic [32:0] position;
    logic [32:0] decision_at;
    amfs_pkg::scan_phase_e phase;
    logic [15:0] frames;

    amfs_pkg::result_t owed[$];
    int fail_count;
    int frames_seen;
    int dones_seen;

    function new();
      restart();
      fail_count  = 0;
      frames_seen = 0;
      dones_seen  = 0;
    endfunction

    function void restart();
      window      = '0;
      position    = '0;
      decision_at = '0;
      phase       = amfs_pkg::PH_SEARCH;
      frames      = '0;
    endfunction

    function void jump_to(logic [63:0] v);
      decision_at = (v > 64'(amfs_pkg::PosMax)) ? amfs_pkg::PosMax : v[32:0];
    endfunction

    function amfs_pkg::result_t done_record(amfs_pkg::end_cause_e c);
      amfs_pkg::result_t r;
      r.kind   = amfs_pkg::KIND_DONE;
      r.offset = '0;
      r.size   = '0;
      r.count  = frames;
      r.cause  = c;
      r.last   = 1'b0;
      return r;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void scan_byte(logic [7:0] b, logic is_last);
      logic [32:0] idx;
      logic [63:0] p;
      logic [31:0] tag;
      logic [31:0] sz;
      amfs_pkg::result_t fr;
      amfs_pkg::result_t batch[$];
      idx      = position;
      window   = {window[55:0], b};
      position = (idx == amfs_pkg::PosMax) ? idx : idx + 33'd1;
      if ((phase == amfs_pkg::PH_SEARCH || phase == amfs_pkg::PH_WALK) &&
          64'(idx) == 64'(decision_at) + 64'd7) begin
        p   = 64'(decision_at);
        tag = window[63:32];
        sz  = {window[7:0], window[15:8], window[23:16], window[31:24]};
        if (!(p + 64'd8 < 64'(file_size))) begin
          phase = amfs_pkg::PH_OWED;
        end else if (phase == amfs_pkg::PH_SEARCH) begin
          if (tag == amfs_pkg::TagMovi) begin
            phase = amfs_pkg::PH_WALK;
            jump_to(p + 64'd4);
          end else begin
            jump_to(p + 64'd1);
          end
        end else if (frames >= frame_cap) begin
          batch.push_back(done_record(amfs_pkg::CAUSE_CAP));
          phase = amfs_pkg::PH_DONE;
        end else if (tag == amfs_pkg::TagVid) begin
          if (sz > size_floor && sz < size_ceil &&
              p + 64'd8 + 64'(sz) <= 64'(file_size)) begin
            fr.kind   = amfs_pkg::KIND_FRAME;
            fr.offset = p[31:0] + 32'd8;
            fr.size   = sz;
            fr.count  = '0;
            fr.cause  = amfs_pkg::CAUSE_INDEX;
            fr.last   = 1'b0;
            batch.push_back(fr);
            frames = frames + 16'd1;
            jump_to(p + 64'd8 + 64'(sz) + 64'(sz[0]));
            if (frames >= frame_cap) begin
              batch.push_back(done_record(amfs_pkg::CAUSE_CAP));
              phase = amfs_pkg::PH_DONE;
            end
          end else begin
            jump_to(p + 64'd8);
          end
        end else if (tag == amfs_pkg::TagAud) begin
          jump_to(p + 64'd8 + 64'(sz) + 64'(sz[0]));
        end else if (tag == amfs_pkg::TagIdx) begin
          batch.push_back(done_record(amfs_pkg::CAUSE_INDEX));
          phase = amfs_pkg::PH_DONE;
        end else begin
          jump_to(p + 64'd1);
        end
      end
      if (is_last) begin
        if (phase != amfs_pkg::PH_DONE) batch.push_back(done_record(amfs_pkg::CAUSE_EOS));
        restart();
      end
      if (batch.size() > 0) begin
        batch[batch.size()-1].last = 1'b1;
        foreach (batch[i]) owed.push_back(batch[i]);
      end
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH %s", $time, msg);
      fail_count++;
    endtask

    task check_result(logic kind, logic [31:0] off, logic [31:0] sz, logic [15:0] cnt,
                      logic [1:0] cause, logic last);
      amfs_pkg::result_t exp;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result kind=%0d off=%0h size=%0h count=%0d cause=%0d",
                         kind, off, sz, cnt, cause));
      end else begin
        exp = owed.pop_front();
        if (exp.kind == amfs_pkg::KIND_FRAME) frames_seen++;
        else dones_seen++;
        if (kind != exp.kind)
          report($sformatf("result_kind got %0d exp %0d", kind, exp.kind));
        if (off != exp.offset)
          report($sformatf("frame_offset got %0h exp %0h", off, exp.offset));
        if (sz != exp.size)
          report($sformatf("frame_size got %0h exp %0h", sz, exp.size));
        if (cnt != exp.count)
          report($sformatf("frame_count got %0d exp %0d", cnt, exp.count));
        if (cause != exp.cause)
          report($sformatf("end_cause got %0d exp %0d", cause, exp.cause));
        if (last != exp.last)
          report($sformatf("last_of_run got %0d exp %0d", last, exp.last));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'd0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        res_kind;
  logic [31:0] res_offset;
  logic [31:0] res_size;
  logic [15:0] res_count;
  logic [1:0]  res_cause;
  logic        res_last;
  logic        cfg_we = 1'b0;
  amfs_pkg::cfg_reg_e cfg_index = amfs_pkg::CFG_FILE_SIZE;
  logic [31:0] cfg_wdata = 32'd0;

  frame_scan_board sb;
  logic [7:0]  file_bytes[$];
  int          file_count = 0;
  int          byte_count = 0;
  logic [31:0] cyc = 32'd0;
  logic [1:0]  stall_mode = 2'd0;

  avi_movi_frame_scanner_core u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .byte_value_i   (in_byte),
    .last_byte_i    (in_last),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_kind_o  (res_kind),
    .frame_offset_o (res_offset),
    .frame_size_o   (res_size),
    .frame_count_o  (res_count),
    .end_cause_o    (res_cause),
    .last_of_run_o  (res_last),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: switch stall pattern whenever the low eight bits of the cycle counter are zero
  always @(posedge clk) begin
    cyc <= cyc + 32'd1;
    if (cyc[7:0] == 8'd0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      2'd2: out_ready <= (cyc % 5 == 0);
      default: out_ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(res_kind, res_offset, res_size, res_count, res_cause, res_last);
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("avi_movi_frame_scanner_core verification failed");
    $finish;
  end

  function void push_be(logic [31:0] w);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(w[i*8 +: 8]);
  endfunction

  function void push_le(logic [31:0] w);
    for (int i = 0; i < 4; i++) file_bytes.push_back(w[i*8 +: 8]);
  endfunction

  function void push_noise(int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(8'($urandom));
  endfunction

  function logic [31:0] any_tag();
    logic [31:0] t;
    case ($urandom_range(0, 3))
      0: t = amfs_pkg::TagMovi;
      1: t = amfs_pkg::TagVid;
      2: t = amfs_pkg::TagAud;
      default: t = amfs_pkg::TagIdx;
    endcase
    return t;
  endfunction

  function void build_file(logic [31:0] floor_v, logic [31:0] ceil_v);
    int          nchunks;
    int          target;
    logic [31:0] sz;
    logic [31:0] hi;
    file_bytes.delete();
    if ($urandom_range(0, 9) < 2) begin
      target = $urandom_range(1, 40);
      while (file_bytes.size() < target) begin
        if ($urandom_range(0, 5) == 0) push_be(any_tag());
        else push_noise(1);
      end
    end else begin
      push_noise($urandom_range(0, 10));
      push_be(amfs_pkg::TagMovi);
      nchunks = $urandom_range(0, 6);
      for (int c = 0; c < nchunks; c++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            if (floor_v < 32'd64 && ceil_v > floor_v + 32'd1) begin
              hi = (ceil_v - 32'd1 < floor_v + 32'd12) ? ceil_v - 32'd1 : floor_v + 32'd12;
              sz = $urandom_range(hi, floor_v + 32'd1);
            end else begin
              sz = $urandom_range(1, 16);
            end
            push_be(amfs_pkg::TagVid);
            push_le(sz);
            push_noise(int'(sz) + int'(sz[0]));
          end
          4: begin
            case ($urandom_range(0, 3))
              0: sz = floor_v;
              1: sz = ceil_v;
              2: sz = 32'd0;
              default: sz = $urandom;
            endcase
            push_be(amfs_pkg::TagVid);
            push_le(sz);
          end
          5, 6: begin
            sz = $urandom_range(0, 9);
            push_be(amfs_pkg::TagAud);
            push_le(sz);
            push_noise(int'(sz) + int'(sz[0]));
          end
          7: push_noise($urandom_range(1, 3));
          8: begin
            push_be(amfs_pkg::TagIdx);
            push_noise(4);
          end
          default: begin
            sz = 32'd5000 + $urandom_range(0, 100);
            push_be(amfs_pkg::TagVid);
            push_le(sz);
            push_noise($urandom_range(0, 4));
          end
        endcase
      end
      push_noise($urandom_range(0, 6));
    end
  endfunction

  task load_config(logic [31:0] fs, logic [31:0] floor_v, logic [31:0] ceil_v,
                   logic [15:0] cap);
    cfg_we    <= 1'b1;
    cfg_index <= amfs_pkg::CFG_FILE_SIZE;
    cfg_wdata <= fs;
    @(posedge clk);
    cfg_index <= amfs_pkg::CFG_SIZE_FLOOR;
    cfg_wdata <= floor_v;
    @(posedge clk);
    cfg_index <= amfs_pkg::CFG_SIZE_CEIL;
    cfg_wdata <= ceil_v;
    @(posedge clk);
    cfg_index <= amfs_pkg::CFG_MAX_FRAMES;
    cfg_wdata <= {16'd0, cap};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.file_size  = fs;
    sb.size_floor = floor_v;
    sb.size_ceil  = ceil_v;
    sb.frame_cap  = cap;
  endtask

  task drive_byte(logic [7:0] b, logic is_last);
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= is_last;
    do @(posedge clk); while (!in_ready);
    sb.scan_byte(b, is_last);
    byte_count++;
  endtask

  task send_file();
    int burst;
    int gap;
    burst = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
    foreach (file_bytes[i]) begin
      if (burst == 0) begin
        in_valid <= 1'b0;
        gap = $urandom_range(1, 6);
        repeat (gap) @(posedge clk);
        burst = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
      end
      drive_byte(file_bytes[i], i == file_bytes.size() - 1);
      burst--;
    end
    in_valid <= 1'b0;
    file_count++;
  endtask

  // hold the sender until every owed result is out, then let the pipe settle
  task await_quiet();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin
    logic [31:0] floor_v;
    logic [31:0] ceil_v;
    logic [31:0] fs;
    logic [15:0] cap;
    int          len;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one-byte file under reset settings: done at end of stream at once
    file_bytes.delete();
    file_bytes.push_back(8'hFF);
    send_file();
    await_quiet();

    // movi, one accepted frame with odd size and padding, then idx1, one trailing byte
    load_config(32'd25, 32'd0, 32'd16, 16'd10);
    file_bytes.delete();
    push_be(amfs_pkg::TagMovi);
    push_be(amfs_pkg::TagVid);
    push_le(32'd3);
    file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'h80);
    file_bytes.push_back(8'h00);
    push_be(amfs_pkg::TagIdx);
    push_le(32'd0);
    file_bytes.push_back(8'hFF);
    send_file();
    await_quiet();

    while (byte_count < ByteTarget) begin
      case ($urandom_range(0, 7))
        0: floor_v = 32'd0;
        1: floor_v = 32'hFFFF_FFFF;
        default: floor_v = $urandom_range(0, 6);
      endcase
      case ($urandom_range(0, 5))
        0: ceil_v = 32'hFFFF_FFFF;
        1: ceil_v = 32'd0;
        default: ceil_v = floor_v + $urandom_range(2, 30);
      endcase
      case ($urandom_range(0, 5))
        0: cap = 16'd0;
        1: cap = 16'd1;
        2: cap = 16'hFFFF;
        3: cap = 16'd2;
        default: cap = 16'($urandom_range(0, 6));
      endcase
      build_file(floor_v, ceil_v);
      len = file_bytes.size();
      case ($urandom_range(0, 9))
        6: fs = 32'(len) - $urandom_range(0, 8);
        7: fs = 32'd0;
        8: fs = 32'hFFFF_FFFF;
        9: fs = $urandom;
        default: fs = 32'(len);
      endcase
      load_config(fs, floor_v, ceil_v, cap);
      send_file();
      await_quiet();
    end

    await_quiet();
    $display("run covered %0d files, %0d bytes, %0d frame descriptors, %0d done records",
             file_count, byte_count, sb.frames_seen, sb.dones_seen);
    $display("settings spanned zero and full-scale bounds, caps 0..65535, off-size files");
    if (sb.fail_count == 0) begin
      $display("avi_movi_frame_scanner_core verification clean");
    end else begin
      $display("avi_movi_frame_scanner_core verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/amfs_pkg.sv
hdl/avi_movi_frame_scanner_core.sv
bench/tb_avi_movi_frame_scanner_core.sv
